[hw/rtl/bcfa_pkg.sv]
package bcfa_pkg;

  // Fixed field widths
  localparam int FRAME_W = 14;  // scan pointer, holds bound + 8
  localparam int LIMIT_W = 13;  // frame_limit, search_end, frame_count
  localparam int START_W = 12;
  localparam int ADDR_W  = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
  localparam logic [7:0]         FULL_BYTE   = 8'hFF;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_STATUS = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRD,
    ST_SCAN,
    ST_MRD,
    ST_MWR,
    ST_ORD,
    ST_OWR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic scan_rd;
    logic scan_skip;
    logic scan_adv;
    logic mark_start;
    logic mark_rd;
    logic mark_wr;
    logic one_rd;
    logic one_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       alloc_fail;
    logic       frame_ok;
    logic       clr_last;
    logic       f_ge_bound;
    logic       byte_full;
    logic       run_hit;
    logic       next_boundary;
    logic       mark_last;
    logic       out_free;
  } sts_t;

endpackage

[hw/rtl/bitmap_contiguous_frame_allocator.sv]
// First-fit contiguous frame allocator over a one-bit-per-frame occupancy bitmap
// (0 free, 1 used) held in a byte-wide single-port-style memory of
// ceil(FRAME_COUNT_MAX/8) entries. After reset a clearing pass writes one byte
// per cycle, and in_stall stays high until it is done; cfg writes are taken at
// any time. One result word per input word, one word in flight at a time; the
// result register lets the next word in while the previous result waits on
// out_stall. A word that ends at once (allocate with count 0 or start at or
// above the bound, free or status beyond the map, unknown op) goes from idle
// straight to the emit state; other free and status words pass through a read
// and a write state first. After the emit state the block returns to idle
// before it takes the next word. An allocate walks the bitmap one frame per
// cycle in the scan state, with a memory read state for each byte entered; a
// fully used byte seen at bit 0 is skipped whole after its read. A granted run
// is then marked by read-modify-write, a read and a write state per byte it touches.
module bitmap_contiguous_frame_allocator #(
  parameter int FRAME_COUNT_MAX = 4096,
  parameter int PAGE_SHIFT      = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: frame_limit
  input  logic                              cfg_wr_en,
  input  logic [bcfa_pkg::LIMIT_W-1:0]      cfg_wr_data,
  // request words
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic [bcfa_pkg::START_W-1:0]      in_search_start,
  input  logic [bcfa_pkg::LIMIT_W-1:0]      in_search_end,
  input  logic [bcfa_pkg::LIMIT_W-1:0]      in_frame_count,
  input  logic [bcfa_pkg::ADDR_W-1:0]       in_byte_address,
  // result words
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_granted,
  output logic [bcfa_pkg::ADDR_W-1:0]       out_granted_address,
  output logic                              out_frame_used
);
  import bcfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, scan, run marking, single-frame access
  bcfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // bitmap memory, scan pointer, run counter, result registers
  bcfa_dpath #(
    .FRAME_COUNT_MAX (FRAME_COUNT_MAX),
    .PAGE_SHIFT      (PAGE_SHIFT)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_operation        (in_operation),
    .in_search_start     (in_search_start),
    .in_search_end       (in_search_end),
    .in_frame_count      (in_frame_count),
    .in_byte_address     (in_byte_address),
    .out_stall           (out_stall),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_granted         (out_granted),
    .out_granted_address (out_granted_address),
    .out_frame_used      (out_frame_used)
  );

`ifndef SYNTH
  // clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("request accepted before bitmap clear finished");

  // a granted result never carries a status bit
  a_grant_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> !out_frame_used)
    else $error("granted result with frame_used set");

  // failed or non-allocate results carry a zero address
  a_no_grant_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_granted_address == '0))
    else $error("nonzero address without grant");

  // granted addresses are page aligned
  a_grant_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> (out_granted_address[PAGE_SHIFT-1:0] == '0))
    else $error("granted address not page aligned");
`endif

endmodule

[hw/rtl/bcfa_ctrl.sv]
module bcfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  bcfa_pkg::sts_t sts,
  output bcfa_pkg::cmd_t cmd,
  output logic          in_stall
);
  import bcfa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (sts.in_op)
            OP_ALLOC:  state_nxt = sts.alloc_fail ? ST_EMIT : ST_SRD;
            OP_FREE,
            OP_STATUS: state_nxt = sts.frame_ok ? ST_ORD : ST_EMIT;
            default:   state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SRD: begin
        state_nxt = sts.f_ge_bound ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.f_ge_bound) state_nxt = ST_EMIT;
        else if (sts.byte_full) state_nxt = ST_SRD;
        else if (sts.run_hit) state_nxt = ST_MRD;
        else if (sts.next_boundary) state_nxt = ST_SRD;
      end
      ST_MRD:  state_nxt = ST_MWR;
      ST_MWR:  state_nxt = sts.mark_last ? ST_EMIT : ST_MRD;
      ST_ORD:  state_nxt = ST_OWR;
      ST_OWR:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE:  cmd.load = in_valid;
      ST_SRD:   cmd.scan_rd = !sts.f_ge_bound;
      ST_SCAN: begin
        if (!sts.f_ge_bound) begin
          if (sts.byte_full) cmd.scan_skip = 1'b1;
          else if (sts.run_hit) cmd.mark_start = 1'b1;
          else cmd.scan_adv = 1'b1;
        end
      end
      ST_MRD:  cmd.mark_rd = 1'b1;
      ST_MWR:  cmd.mark_wr = 1'b1;
      ST_ORD:  cmd.one_rd = 1'b1;
      ST_OWR:  cmd.one_wr = 1'b1;
      ST_EMIT: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/bcfa_dpath.sv]
module bcfa_dpath #(
  parameter int FRAME_COUNT_MAX = 4096,
  parameter int PAGE_SHIFT      = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bcfa_pkg::LIMIT_W-1:0]      cfg_wr_data,
  input  logic [1:0]                        in_operation,
  input  logic [bcfa_pkg::START_W-1:0]      in_search_start,
  input  logic [bcfa_pkg::LIMIT_W-1:0]      in_search_end,
  input  logic [bcfa_pkg::LIMIT_W-1:0]      in_frame_count,
  input  logic [bcfa_pkg::ADDR_W-1:0]       in_byte_address,
  input  logic                              out_stall,
  input  bcfa_pkg::cmd_t                    cmd,
  output bcfa_pkg::sts_t                    sts,
  output logic                              out_valid,
  output logic                              out_granted,
  output logic [bcfa_pkg::ADDR_W-1:0]       out_granted_address,
  output logic                              out_frame_used
);
  import bcfa_pkg::*;

  localparam int MAP_BYTES = (FRAME_COUNT_MAX + 7) / 8;
  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam logic [AW-1:0]     CLR_LAST = AW'(MAP_BYTES - 1);
  localparam logic [ADDR_W-1:0] FRAMES   = ADDR_W'(FRAME_COUNT_MAX);

  logic [7:0]         map_r [MAP_BYTES];
  logic [7:0]         rd_data_r;
  logic [LIMIT_W-1:0] frame_limit_r;
  logic [AW-1:0]      clr_r;
  op_t                op_r;
  logic [LIMIT_W-1:0] bound_r;
  logic [LIMIT_W-1:0] count_r;
  logic [FRAME_W-1:0] f_r;
  logic [LIMIT_W-1:0] run_r;
  logic [FRAME_W-1:0] last_r;
  logic [AW-1:0]      one_idx_r;
  logic [2:0]         one_bit_r;
  logic               res_granted_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic               res_used_r;
  logic               out_valid_r;
  logic               out_granted_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_used_r;

  logic [LIMIT_W-1:0] lim_min;
  logic [LIMIT_W-1:0] bound_in;
  logic [ADDR_W-1:0]  one_frame;
  logic [ADDR_W-1:0]  one_byte;
  logic [ADDR_W-1:0]  f_byte;
  logic [AW-1:0]      f_idx;
  logic               cur_bit;
  logic [LIMIT_W-1:0] run_inc;
  logic [FRAME_W-1:0] f_inc;
  logic [FRAME_W-1:0] first;
  logic [2:0]         mark_hi;
  logic [7:0]         mark_mask;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;

  // effective bound: min of search_end, frame_limit and map size
  always_comb begin
    lim_min  = (in_search_end < frame_limit_r) ? in_search_end : frame_limit_r;
    bound_in = (ADDR_W'(lim_min) > FRAMES) ? LIMIT_W'(FRAME_COUNT_MAX) : lim_min;
  end

  assign one_frame = in_byte_address >> PAGE_SHIFT;
  assign one_byte  = one_frame >> 3;
  assign f_byte    = ADDR_W'(f_r) >> 3;
  assign f_idx     = f_byte[AW-1:0];
  assign cur_bit   = rd_data_r[f_r[2:0]];
  assign run_inc   = run_r + LIMIT_W'(1);
  assign f_inc     = f_r + FRAME_W'(1);
  assign first     = f_r + FRAME_W'(1) - FRAME_W'(count_r);

  // bits of the current byte that fall inside the run
  always_comb begin
    mark_hi = (sts.mark_last) ? last_r[2:0] : 3'd7;
    for (int i = 0; i < 8; i++) begin
      mark_mask[i] = (3'(i) >= f_r[2:0]) && (3'(i) <= mark_hi);
    end
  end

  always_comb begin
    sts.in_op         = in_operation;
    sts.alloc_fail    = (in_frame_count == '0) ||
                        (LIMIT_W'(in_search_start) >= bound_in);
    sts.frame_ok      = one_frame < FRAMES;
    sts.clr_last      = clr_r == CLR_LAST;
    sts.f_ge_bound    = f_r >= FRAME_W'(bound_r);
    sts.byte_full     = (f_r[2:0] == 3'd0) && (rd_data_r == FULL_BYTE);
    sts.run_hit       = !cur_bit && (run_inc == count_r);
    sts.next_boundary = f_inc[2:0] == 3'd0;
    sts.mark_last     = f_r[FRAME_W-1:3] == last_r[FRAME_W-1:3];
    sts.out_free      = !out_valid_r || !out_stall;
  end

  // bitmap port muxing
  always_comb begin
    rd_en   = cmd.scan_rd || cmd.mark_rd || cmd.one_rd;
    rd_addr = cmd.one_rd ? one_idx_r : f_idx;
    wr_en   = cmd.clr_wr || cmd.mark_wr || (cmd.one_wr && (op_r == OP_FREE));
    if (cmd.clr_wr) begin
      wr_addr = clr_r;
      wr_data = 8'h00;
    end else if (cmd.mark_wr) begin
      wr_addr = f_idx;
      wr_data = rd_data_r | mark_mask;
    end else begin
      wr_addr = one_idx_r;
      wr_data = rd_data_r & ~(8'h01 << one_bit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= map_r[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_limit_r <= LIMIT_RESET;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) frame_limit_r <= cfg_wr_data;
      if (cmd.clr_wr) clr_r <= clr_r + AW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r          <= op_t'(in_operation);
      bound_r       <= bound_in;
      count_r       <= in_frame_count;
      f_r           <= FRAME_W'(in_search_start);
      run_r         <= '0;
      one_idx_r     <= one_byte[AW-1:0];
      one_bit_r     <= one_frame[2:0];
      res_granted_r <= 1'b0;
      res_addr_r    <= '0;
      res_used_r    <= 1'b0;
    end
    if (cmd.scan_skip) begin
      f_r   <= f_r + FRAME_W'(8);
      run_r <= '0;
    end
    if (cmd.scan_adv) begin
      f_r   <= f_inc;
      run_r <= cur_bit ? '0 : run_inc;
    end
    if (cmd.mark_start) begin
      f_r           <= first;
      last_r        <= f_r;
      res_granted_r <= 1'b1;
      res_addr_r    <= ADDR_W'(first) << PAGE_SHIFT;
    end
    if (cmd.mark_wr) begin
      f_r <= {f_r[FRAME_W-1:3] + (FRAME_W-3)'(1), 3'd0};
    end
    if (cmd.one_wr && (op_r == OP_STATUS)) begin
      res_used_r <= rd_data_r[one_bit_r];
    end
    if (cmd.out_load) begin
      out_granted_r <= res_granted_r;
      out_addr_r    <= res_addr_r;
      out_used_r    <= res_used_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted         = out_granted_r;
  assign out_granted_address = out_addr_r;
  assign out_frame_used      = out_used_r;

endmodule

[tb/bitmap_contiguous_frame_allocator_tb.sv]
module bitmap_contiguous_frame_allocator_tb;
  import bcfa_pkg::*;

  localparam int          MAP_FRAMES = 4096;
  localparam int          PAGE_SHIFT = 12;
  // operation code the block must treat as a no-op
  localparam logic [1:0]  OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] lo_frame;
    logic [12:0] hi_frame;
    logic [12:0] count;
    logic [31:0] addr;
  } frame_req_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] grant_addr;
    logic        used;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [11:0] in_search_start = '0;
  logic [12:0] in_search_end = '0;
  logic [12:0] in_frame_count = '0;
  logic [31:0] in_byte_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_granted;
  logic [31:0] out_granted_address;
  logic        out_frame_used;

  bitmap_contiguous_frame_allocator #(
    .FRAME_COUNT_MAX(MAP_FRAMES),
    .PAGE_SHIFT     (PAGE_SHIFT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_search_start    (in_search_start),
    .in_search_end      (in_search_end),
    .in_frame_count     (in_frame_count),
    .in_byte_address    (in_byte_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_granted        (out_granted),
    .out_granted_address(out_granted_address),
    .out_frame_used     (out_frame_used)
  );

  // Shadow of the block: occupancy bitmap plus the frame_limit register.
  logic [MAP_FRAMES-1:0] occ_map = '0;
  logic [12:0]           limit_q = LIMIT_RESET;

  frame_req_t    frame_req_q[$];      // words waiting for the driver
  frame_result_t frame_results_q[$];  // expected result words, oldest first
  int unsigned   used_frames[$];      // frames we granted, used to aim frees
  int            mismatches = 0;
  bit            in_took = 1'b0;      // request word accepted at last rising edge
  bit            steady_run = 1'b0;   // no idling on either side while set

  initial begin
    forever #2 clk = ~clk;
  end

  // Run-away guard, far beyond the slowest legal run of this stimulus.
  initial begin
    #80000000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  function automatic frame_req_t mk_req(input logic [1:0] op, input logic [11:0] lo_frame,
                                        input logic [12:0] hi_frame,
                                        input logic [12:0] count, input logic [31:0] addr);
    return '{op, lo_frame, hi_frame, count, addr};
  endfunction

  // First-fit search over the shadow bitmap. Full bytes entered at bit 0 are
  // hopped over whole and the run restarts at bit 0 of the next byte.
  task automatic predict_frame_result(input frame_req_t w);
    frame_result_t r;
    int unsigned   bound, f, run, first, frame, k, want_cnt;
    bit            hit;
    r = '0;
    hit = 1'b0;
    run = 0;
    want_cnt = 32'(w.count);
    frame = w.addr >> PAGE_SHIFT;
    case (w.op)
      OP_ALLOC: begin
        bound = 32'(w.hi_frame);
        if (32'(limit_q) < bound) bound = 32'(limit_q);
        if (MAP_FRAMES < bound) bound = MAP_FRAMES;
        f = 32'(w.lo_frame);
        if (want_cnt != 0) begin
          while (f < bound && !hit) begin
            if (f % 8 == 0 && occ_map[f +: 8] == FULL_BYTE) begin
              run = 0;
              f += 8;
            end else begin
              if (occ_map[f]) begin
                run = 0;
              end else begin
                run++;
                if (run == want_cnt) hit = 1'b1;
              end
              if (!hit) f++;
            end
          end
        end
        if (hit) begin
          first = f + 1 - want_cnt;
          for (k = first; k <= f; k++) begin
            occ_map[k] = 1'b1;
            used_frames.push_back(k);
          end
          r.granted = 1'b1;
          r.grant_addr = first << PAGE_SHIFT;
        end
      end
      OP_FREE: begin
        if (frame < MAP_FRAMES) occ_map[frame] = 1'b0;
      end
      OP_STATUS: begin
        if (frame < MAP_FRAMES) r.used = occ_map[frame];
      end
      default: begin
      end
    endcase
    frame_results_q.push_back(r);
  endtask

  // Sampling side: request accepts feed the shadow, result accepts are checked.
  always @(posedge clk) begin
    frame_result_t want;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took)
      predict_frame_result(mk_req(in_operation, in_search_start, in_search_end,
                                  in_frame_count, in_byte_address));
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("word with none expected", 32'd0, out_granted_address);
      end else begin
        want = frame_results_q.pop_front();
        if (out_granted !== want.granted)
          report_mismatch("granted", 32'(want.granted), 32'(out_granted));
        if (out_granted_address !== want.grant_addr)
          report_mismatch("granted_address", want.grant_addr, out_granted_address);
        if (out_frame_used !== want.used)
          report_mismatch("frame_used", 32'(want.used), 32'(out_frame_used));
      end
    end
  end

  // Request driver: holds a word until taken, then may idle before the next one.
  always @(negedge clk) begin
    frame_req_t w;
    if (rst_n && (!in_valid || in_took)) begin
      if (frame_req_q.size() > 0 && (steady_run || $urandom_range(0, 99) >= 19)) begin
        w = frame_req_q.pop_front();
        in_valid        <= 1'b1;
        in_operation    <= w.op;
        in_search_start <= w.lo_frame;
        in_search_end   <= w.hi_frame;
        in_frame_count  <= w.count;
        in_byte_address <= w.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure, independent of what the block is doing.
  always @(negedge clk) begin
    out_stall <= !steady_run && ($urandom_range(0, 99) < 19);
  end

  // Address inside a given frame with a random page offset.
  function automatic logic [31:0] frame_addr(input int unsigned frame);
    return (frame << PAGE_SHIFT) | $urandom_range(0, (1 << PAGE_SHIFT) - 1);
  endfunction

  function automatic frame_req_t random_req();
    frame_req_t  w;
    int unsigned pick, kind, base, idx, fr;
    w = '{2'($urandom), 12'($urandom), 13'($urandom), 13'($urandom), $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.op = OP_ALLOC;
      kind = $urandom_range(0, 99);
      w.lo_frame = 12'($urandom_range(0, MAP_FRAMES - 1));
      w.count = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(1, 12)) :
                                              13'($urandom_range(1, 4));
      if (kind < 3) begin
        // whole-map walk: slow, so kept rare
        w.hi_frame = $urandom_range(0, 1) ? 13'd8191 : 13'd4096;
        w.count = 13'($urandom_range(1, 24));
      end else if (kind < 25) begin
        // packed zones build full bytes that later searches must hop
        base = ($urandom_range(0, 3) == 3) ? 3840 : $urandom_range(0, 2) * 1024;
        w.lo_frame = 12'(base + $urandom_range(0, 15));
        w.hi_frame = 13'(base + 256);
        w.count = 13'($urandom_range(1, 16));
      end else if (kind < 30) begin
        w.hi_frame = 13'(32'(w.lo_frame) + $urandom_range(0, 64));
        w.count = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(4097, 8191));
      end else if (kind < 34) begin
        w.hi_frame = 13'($urandom_range(0, 32'(w.lo_frame)));
      end else begin
        w.hi_frame = 13'(32'(w.lo_frame) + $urandom_range(0, 64));
      end
    end else if (pick < 70) begin
      w.op = OP_FREE;
      kind = $urandom_range(0, 99);
      if (kind < 60 && used_frames.size() > 0) begin
        idx = $urandom_range(0, used_frames.size() - 1);
        fr = used_frames[idx];
        used_frames.delete(idx);
        w.addr = frame_addr(fr);
      end else if (kind < 85) begin
        w.addr = frame_addr($urandom_range(0, MAP_FRAMES - 1));
      end
    end else if (pick < 93) begin
      w.op = OP_STATUS;
      kind = $urandom_range(0, 99);
      if (kind < 50 && used_frames.size() > 0)
        w.addr = frame_addr(used_frames[$urandom_range(0, used_frames.size() - 1)]);
      else if (kind < 85)
        w.addr = frame_addr($urandom_range(0, MAP_FRAMES - 1));
    end else begin
      w.op = OP_UNKNOWN;
    end
    return w;
  endfunction

  // Wait until the block has nothing queued, in flight or owed.
  task automatic drain_words();
    while (frame_req_q.size() != 0 || in_valid || frame_results_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [12:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    limit_q = value;
  endtask

  // Fed a few words at a time so frees can aim at frames granted just before.
  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      while (frame_req_q.size() >= 4) @(posedge clk);
      frame_req_q.push_back(random_req());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // register write lands during the clearing pass, which is allowed
    write_limit(13'd4096);

    // directed: count zero, first fit from frame 0, full byte hop,
    // free then status, top frame, empty window, oversize counts,
    // out-of-map free and status, unknown operation
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd0, 13'd4096, 13'd0, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd0, 13'd4096, 13'd1, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd0, 13'd8191, 13'd7, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd0, 13'd16, 13'd8, 32'd0));
    frame_req_q.push_back(mk_req(OP_STATUS, 12'd0, 13'd0, 13'd0, 32'h0000_3000));
    frame_req_q.push_back(mk_req(OP_FREE, 12'd0, 13'd0, 13'd0, 32'h0000_3FFF));
    frame_req_q.push_back(mk_req(OP_STATUS, 12'd0, 13'd0, 13'd0, 32'h0000_3ABC));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd0, 13'd16, 13'd1, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd2, 13'd24, 13'd3, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd4095, 13'd4096, 13'd1, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd4095, 13'd8191, 13'd1, 32'd0));
    frame_req_q.push_back(mk_req(OP_STATUS, 12'd0, 13'd0, 13'd0, 32'h00FF_F000));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd100, 13'd100, 13'd1, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd10, 13'd4096, 13'd4096, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd0, 13'd8191, 13'd8191, 32'hFFFF_FFFF));
    frame_req_q.push_back(mk_req(OP_FREE, 12'd0, 13'd0, 13'd0, 32'hFFFF_FFFF));
    frame_req_q.push_back(mk_req(OP_STATUS, 12'd0, 13'd0, 13'd0, 32'hFFFF_FFFF));
    frame_req_q.push_back(mk_req(OP_STATUS, 12'd0, 13'd0, 13'd0, 32'h0100_0000));
    frame_req_q.push_back(mk_req(OP_UNKNOWN, 12'hFFF, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF));
    frame_req_q.push_back(mk_req(OP_FREE, 12'd0, 13'd0, 13'd0, 32'd0));
    frame_req_q.push_back(mk_req(OP_ALLOC, 12'd0, 13'd64, 13'd2, 32'd0));
    frame_req_q.push_back(mk_req(OP_STATUS, 12'd0, 13'd0, 13'd0, 32'h0000_0123));
    drain_words();

    // limit above the map size: map size bounds the search
    write_limit(13'd8191);
    run_random(700);
    drain_words();

    // no frames at all: every allocate fails
    write_limit(13'd0);
    run_random(60);
    drain_words();

    // mid-range limit, run back to back with no idling on either side
    write_limit(13'($urandom_range(1024, 3072)));
    steady_run = 1'b1;
    run_random(500);
    drain_words();
    steady_run = 1'b0;

    write_limit(13'd4096);
    run_random(690);
    drain_words();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
